// ===== design/bgmt_pkg.sv =====
package bgmt_pkg;

	// Size of the group table and of each task counter.
	localparam int GROUPS     = 8;
	localparam int COUNT_BITS = 16;
	localparam int GRP_AW     = $clog2(GROUPS);
	localparam int SCAN_CW    = $clog2(GROUPS + 1);

	// Boost range and register reset values.
	localparam logic signed [7:0] BOOST_HI   = 8'sd100;
	localparam logic signed [7:0] BOOST_LO   = -8'sd100;
	localparam logic [31:0]       HOLD_RESET = 32'd50000000;

	// Configuration register indexes.
	localparam logic [7:0] CFG_HOLD_TIME = 8'd0;
	localparam logic [7:0] CFG_HOLD_ALL  = 8'd1;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_ENQUEUE = 3'd0,
		REQ_DEQUEUE = 3'd1,
		REQ_SET     = 3'd2,
		REQ_QUERY   = 3'd3,
		REQ_MOVE    = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_t;

	// One entry of the group table.
	typedef struct packed {
		logic signed [7:0]       boost;
		logic [COUNT_BITS-1:0]   tasks;
		logic [63:0]             stamp;
	} grp_word_t;

	// A group is active while it has tasks or its hold time has not run out.
	function automatic logic is_active(grp_word_t w, logic [63:0] now, logic [31:0] hold);
		logic [63:0] age;
		age = now - w.stamp;
		return (w.tasks != '0) || (age <= {32'd0, hold});
	endfunction

endpackage

// ===== design/boost_group_max_tracker.sv =====
// A transaction is accepted while the block is idle; its group entry is read and modified,
// a move task also updates the destination entry, and a transaction that needs it rescans
// the whole group table before the result is registered. One transaction is worked on at a
// time; a new one is taken while the result waits in the output register.
// Reset clears the maximum, the control state and the per-entry valid flags, so the
// whole group table reads as zero; the registers return to their reset values.
module boost_group_max_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     req_type,
	input  logic [2:0]                     group,
	input  logic [2:0]                     dst_group,
	input  logic signed [7:0]              new_boost,
	input  logic [63:0]                    now,
	input  logic                           task_is_rt,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [7:0]              cpu_boost
);

	import bgmt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MOV2,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// Registers and latched transaction.
	logic [31:0]        hold_time_q;
	logic               hold_all_q;
	req_t               req_q;
	logic [GRP_AW-1:0]  g_q;
	logic [GRP_AW-1:0]  d_q;
	logic               g_ok_q;
	logic               move_ok_q;
	logic signed [7:0]  nb_q;
	logic [63:0]        now_q;
	logic               rt_q;

	// Tracked maximum and rescan accumulator.
	logic signed [7:0]  max_boost_q;
	logic [63:0]        max_stamp_q;
	logic [SCAN_CW-1:0] scan_cnt_q;
	logic               scan_v_s1;
	logic               found_q;
	logic signed [7:0]  best_q;
	logic [63:0]        ts_q;

	logic [GROUPS-1:0]  grp_vld_q;
	logic               vld_s1;
	logic               out_valid_q;
	logic signed [7:0]  cpu_boost_q;

	// Table port signals.
	logic               ren;
	logic [GRP_AW-1:0]  raddr;
	logic               wen;
	logic [GRP_AW-1:0]  waddr;
	grp_word_t          wdata;
	logic [$bits(grp_word_t)-1:0] ram_rdata;
	grp_word_t          rd_word;

	logic               in_fire;
	logic               grp_in_ok;
	logic               dst_in_ok;
	logic signed [7:0]  nb_sat;
	logic signed [7:0]  nb_eff;
	logic               active_g;
	logic               set_take;
	logic               set_rescan;
	logic               go_scan;
	logic               scan_more;
	logic               cand;
	logic               found_n;
	logic signed [7:0]  best_n;
	logic [63:0]        ts_n;
	logic [63:0]        max_age;
	logic               out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign cpu_boost = cpu_boost_q;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign grp_in_ok = (32'(group) < GROUPS);
	assign dst_in_ok = (32'(dst_group) < GROUPS);

	// Saturate the requested boost into the legal range.
	always_comb begin
		if (new_boost > BOOST_HI) begin
			nb_sat = BOOST_HI;
		end else if (new_boost < BOOST_LO) begin
			nb_sat = BOOST_LO;
		end else begin
			nb_sat = new_boost;
		end
	end

	// Entries never written read as zero.
	assign rd_word = vld_s1 ? grp_word_t'(ram_rdata) : '0;

	assign nb_eff     = (req_q == REQ_CLEAR) ? 8'sd0 : nb_q;
	assign active_g   = is_active(rd_word, now_q, hold_time_q);
	assign set_take   = (nb_eff > max_boost_q) && active_g;
	assign set_rescan = !set_take && (max_boost_q == rd_word.boost) && (rd_word.boost > nb_eff);
	assign max_age    = now_q - max_stamp_q;
	assign scan_more  = (scan_cnt_q < SCAN_CW'(GROUPS));

	// Decide whether the latched transaction needs a rescan.
	always_comb begin
		go_scan = 1'b0;
		case (req_q) inside
			REQ_ENQUEUE: go_scan = g_ok_q && (wdata.tasks == COUNT_BITS'(1));
			REQ_SET, REQ_CLEAR: go_scan = g_ok_q && set_rescan;
			REQ_QUERY: go_scan = (max_age > {32'd0, hold_time_q});
			default: go_scan = 1'b0;
		endcase
	end

	// Running maximum over the active groups; a tie goes to the higher index.
	assign cand    = scan_v_s1 && active_g && (!found_q || (rd_word.boost >= best_q));
	assign found_n = found_q || cand;
	assign best_n  = cand ? rd_word.boost : best_q;
	assign ts_n    = cand ? rd_word.stamp : ts_q;

	// Table read address.
	always_comb begin
		ren   = 1'b0;
		raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				ren   = in_valid && grp_in_ok;
				raddr = GRP_AW'(group);
			end
			ST_MOD: begin
				ren   = (req_q == REQ_MOVE) && move_ok_q;
				raddr = d_q;
			end
			ST_SCAN: begin
				ren   = scan_more;
				raddr = scan_cnt_q[GRP_AW-1:0];
			end
			default: begin
				ren   = 1'b0;
				raddr = '0;
			end
		endcase
	end

	// Modified entry written back to the table.
	always_comb begin
		wen   = 1'b0;
		waddr = g_q;
		wdata = rd_word;
		if (state_q == ST_MOD) begin
			case (req_q) inside
				REQ_ENQUEUE: begin
					wen = g_ok_q;
					if (rd_word.tasks != '1) begin
						wdata.tasks = rd_word.tasks + COUNT_BITS'(1);
					end
					if (hold_all_q || rt_q) begin
						wdata.stamp = now_q;
					end
				end
				REQ_DEQUEUE: begin
					wen = g_ok_q;
					if (rd_word.tasks != '0) begin
						wdata.tasks = rd_word.tasks - COUNT_BITS'(1);
					end
				end
				REQ_SET, REQ_CLEAR: begin
					wen         = g_ok_q;
					wdata.boost = nb_eff;
				end
				REQ_MOVE: begin
					wen = move_ok_q;
					if (rd_word.tasks != '0) begin
						wdata.tasks = rd_word.tasks - COUNT_BITS'(1);
					end
				end
				default: wen = 1'b0;
			endcase
		end else if (state_q == ST_MOV2) begin
			wen   = 1'b1;
			waddr = d_q;
			if (rd_word.tasks != '1) begin
				wdata.tasks = rd_word.tasks + COUNT_BITS'(1);
			end
			wdata.stamp = now_q;
		end
	end

	bgmt_ram #(
		.WIDTH($bits(grp_word_t)),
		.DEPTH(GROUPS)
	) u_table (
		.clk  (clk),
		.wen  (wen),
		.waddr(waddr),
		.wdata(wdata),
		.ren  (ren),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, tracked maximum, registers and output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_time_q <= HOLD_RESET;
			hold_all_q  <= 1'b0;
			req_q       <= REQ_QUERY;
			g_q         <= '0;
			d_q         <= '0;
			g_ok_q      <= 1'b0;
			move_ok_q   <= 1'b0;
			nb_q        <= '0;
			now_q       <= '0;
			rt_q        <= 1'b0;
			max_boost_q <= '0;
			max_stamp_q <= '0;
			scan_cnt_q  <= '0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			ts_q        <= '0;
			grp_vld_q   <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			cpu_boost_q <= '0;
		end else begin
			// Configuration writes.
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HOLD_TIME) begin
					hold_time_q <= cfg_data;
				end else if (cfg_index == CFG_HOLD_ALL) begin
					hold_all_q <= cfg_data[0];
				end
			end

			// Valid flag follows each table read.
			if (ren) begin
				vld_s1 <= grp_vld_q[raddr];
			end
			if (wen) begin
				grp_vld_q[waddr] <= 1'b1;
			end

			// Result transaction enters or leaves the output register.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						req_q     <= req_t'(req_type);
						g_q       <= GRP_AW'(group);
						d_q       <= GRP_AW'(dst_group);
						g_ok_q    <= grp_in_ok;
						move_ok_q <= grp_in_ok && dst_in_ok && (group != dst_group);
						nb_q      <= nb_sat;
						now_q     <= now;
						rt_q      <= task_is_rt;
						state_q   <= ST_MOD;
					end
				end
				ST_MOD: begin
					if ((req_q == REQ_SET || req_q == REQ_CLEAR) && g_ok_q && set_take) begin
						max_boost_q <= nb_eff;
						max_stamp_q <= rd_word.stamp;
					end
					if (req_q == REQ_MOVE && move_ok_q) begin
						max_stamp_q <= now_q - {32'd0, hold_time_q};
						state_q     <= ST_MOV2;
					end else if (go_scan) begin
						scan_cnt_q <= '0;
						scan_v_s1  <= 1'b0;
						found_q    <= 1'b0;
						best_q     <= '0;
						ts_q       <= now_q;
						state_q    <= ST_SCAN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MOV2: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					found_q <= found_n;
					best_q  <= best_n;
					ts_q    <= ts_n;
					if (scan_more) begin
						scan_cnt_q <= scan_cnt_q + SCAN_CW'(1);
						scan_v_s1  <= 1'b1;
					end else begin
						scan_v_s1   <= 1'b0;
						max_boost_q <= found_n ? best_n : 8'sd0;
						max_stamp_q <= ts_n;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						cpu_boost_q <= max_boost_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/bgmt_ram.sv =====
module bgmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule
